>>> src/sdwq_pkg.sv
// Shared types, constants and helpers for the sorted deadline wake queue.
package sdwq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int MODE_W  = 2;
    localparam int TID_W   = 8;
    localparam int DL_W    = 64;
    localparam int ENTRY_W = DL_W + TID_W;

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] count_t;
    typedef logic [CW:0]   logical_t;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [TID_W-1:0] thread;
    } entry_t;

    // Request modes (code 3 is ignored)
    typedef enum logic [MODE_W-1:0] {
        MODE_SLEEP = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_WAKE  = 2'd2
    } mode_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_SCAN,
        ST_FULL_ERR,
        ST_TICK_SCAN,
        ST_WAKE_SCAN,
        ST_WAKE_SHIFT
    } state_t;

    // Entry RAM read address selection (logical positions from the head)
    typedef enum logic [2:0] {
        RD_NONE,
        RD_HEAD,
        RD_HEAD_NEXT,
        RD_TAIL,
        RD_IDX_P1,
        RD_IDX_P2,
        RD_IDX_M2
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_MOVE
    } wr_op_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_ERR,
        OUT_WAKE,
        OUT_PEND_MID,
        OUT_PEND_LAST
    } out_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        rd_op_t  rd_op;
        wr_op_t  wr_op;
        idx_op_t idx_op;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    head_inc;
        out_op_t out_op;
        logic    pend_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              count_zero;
        logic              idx_zero;
        logic              idx_lt_count;
        logic              idx_p1_lt_count;
        logic              rd_le_key;
        logic              rd_match;
        logic              slot_free;
        logic              pend_valid;
        count_t            count;
    } status_t;

    // Map a logical position (from the head) to a physical RAM address
    function automatic addr_t phys_addr(addr_t head, logical_t lg);
        logic [CW+1:0] sum;
        sum = {{(CW+2-AW){1'b0}}, head} + {1'b0, lg};
        if (sum >= (CW+2)'(QUEUE_DEPTH))
        begin
            sum = sum - (CW+2)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

>>> src/sorted_deadline_wake_queue_core.sv
// Top level of the sorted deadline wake queue.
// Holds up to 16 sleeping threads in a circular entry RAM kept in deadline
// order. A request is captured and dispatched, then walks the entries
// through the single RAM read port: a sleep moves every entry with a later
// deadline, a tick pops one due entry per cycle from the head while the result
// register can take its results, and an early wake scans to the match and then
// closes the gap. A stalled result register holds a tick or wake walk and a full
// error result. A new request is taken while the last result of the previous one still waits in the output register.
module sorted_deadline_wake_queue_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sdwq_pkg::MODE_W-1:0]  mode,
    input  logic [sdwq_pkg::TID_W-1:0]   thread_id,
    input  logic [sdwq_pkg::DL_W-1:0]    sleep_clocks,
    input  logic [sdwq_pkg::DL_W-1:0]    now_time,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         woken_valid,
    output logic [sdwq_pkg::TID_W-1:0]   woken_thread,
    output logic                         full_error,
    output logic                         last
);

    sdwq_pkg::cmd_t    cmd;
    sdwq_pkg::status_t status;

    sdwq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sdwq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .thread_id    (thread_id),
        .sleep_clocks (sleep_clocks),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .woken_valid  (woken_valid),
        .woken_thread (woken_thread),
        .full_error   (full_error),
        .last         (last)
    );

    // Occupancy never exceeds the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= sdwq_pkg::count_t'(sdwq_pkg::QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // No held tick result survives into the idle state
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !status.pend_valid)
        else $error("held tick result left behind");

    // An error result never names a thread
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_error) |-> (!woken_valid && last))
        else $error("malformed full error result");

    // An accepted request blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while busy");

endmodule

>>> src/sdwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sdwq_dpath.sv
// Datapath: request registers, entry RAM, queue pointers and result register.
module sdwq_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sdwq_pkg::cmd_t               cmd,
    output sdwq_pkg::status_t            status,
    input  logic [sdwq_pkg::MODE_W-1:0]  mode,
    input  logic [sdwq_pkg::TID_W-1:0]   thread_id,
    input  logic [sdwq_pkg::DL_W-1:0]    sleep_clocks,
    input  logic [sdwq_pkg::DL_W-1:0]    now_time,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         woken_valid,
    output logic [sdwq_pkg::TID_W-1:0]   woken_thread,
    output logic                         full_error,
    output logic                         last
);

    // Request registers
    logic [sdwq_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [sdwq_pkg::TID_W-1:0]  thread_reg, thread_next;
    logic [sdwq_pkg::DL_W-1:0]   key_reg, key_next;

    // Queue pointers
    sdwq_pkg::count_t idx_reg, idx_next;
    sdwq_pkg::count_t count_reg, count_next;
    sdwq_pkg::addr_t  head_reg, head_next;

    // Held tick result, emitted once the next head entry is known
    logic                       pend_valid_reg, pend_valid_next;
    logic [sdwq_pkg::TID_W-1:0] pend_thread_reg, pend_thread_next;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic                       woken_valid_reg, woken_valid_next;
    logic [sdwq_pkg::TID_W-1:0] woken_thread_reg, woken_thread_next;
    logic                       full_error_reg, full_error_next;
    logic                       last_reg, last_next;

    // RAM ports
    logic                          ram_wr_en;
    sdwq_pkg::addr_t               ram_wr_addr;
    logic [sdwq_pkg::ENTRY_W-1:0]  ram_wr_data;
    logic                          ram_rd_en;
    sdwq_pkg::addr_t               ram_rd_addr;
    logic [sdwq_pkg::ENTRY_W-1:0]  ram_rd_data;
    sdwq_pkg::entry_t              rd_entry;
    sdwq_pkg::entry_t              new_entry;
    sdwq_pkg::logical_t            rd_logical;
    sdwq_pkg::logical_t            idx_ext;
    logic                          slot_free;

    sdwq_ram #(
        .WIDTH (sdwq_pkg::ENTRY_W),
        .DEPTH (sdwq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry  = sdwq_pkg::entry_t'(ram_rd_data);
    assign new_entry = '{deadline: key_reg, thread: thread_reg};
    assign idx_ext   = {1'b0, idx_reg};
    assign slot_free = !out_valid_reg || !out_stall;

    // Read address select
    always_comb
    begin
        case (cmd.rd_op)
            sdwq_pkg::RD_HEAD:      rd_logical = '0;
            sdwq_pkg::RD_HEAD_NEXT: rd_logical = sdwq_pkg::logical_t'(1);
            sdwq_pkg::RD_TAIL:      rd_logical = {1'b0, count_reg} - sdwq_pkg::logical_t'(1);
            sdwq_pkg::RD_IDX_P1:    rd_logical = idx_ext + sdwq_pkg::logical_t'(1);
            sdwq_pkg::RD_IDX_P2:    rd_logical = idx_ext + sdwq_pkg::logical_t'(2);
            sdwq_pkg::RD_IDX_M2:    rd_logical = idx_ext - sdwq_pkg::logical_t'(2);
            default:                rd_logical = '0;
        endcase
    end

    assign ram_rd_en   = (cmd.rd_op != sdwq_pkg::RD_NONE);
    assign ram_rd_addr = sdwq_pkg::phys_addr(head_reg, rd_logical);

    // Write port: new entry or an entry moved by one place
    assign ram_wr_en   = (cmd.wr_op != sdwq_pkg::WR_NONE);
    assign ram_wr_addr = sdwq_pkg::phys_addr(head_reg, idx_ext);
    assign ram_wr_data = (cmd.wr_op == sdwq_pkg::WR_NEW) ? new_entry : ram_rd_data;

    // Request capture; the key is the deadline for a sleep, the time otherwise
    always_comb
    begin
        mode_next   = mode_reg;
        thread_next = thread_reg;
        key_next    = key_reg;
        if (cmd.capture)
        begin
            mode_next   = mode;
            thread_next = thread_id;
            if (mode == sdwq_pkg::MODE_SLEEP)
            begin
                key_next = now_time + sleep_clocks;
            end
            else
            begin
                key_next = now_time;
            end
        end
    end

    // Pointer updates
    always_comb
    begin
        case (cmd.idx_op)
            sdwq_pkg::IDX_ZERO:  idx_next = '0;
            sdwq_pkg::IDX_COUNT: idx_next = count_reg;
            sdwq_pkg::IDX_INC:   idx_next = idx_reg + sdwq_pkg::count_t'(1);
            sdwq_pkg::IDX_DEC:   idx_next = idx_reg - sdwq_pkg::count_t'(1);
            default:             idx_next = idx_reg;
        endcase

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + sdwq_pkg::count_t'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - sdwq_pkg::count_t'(1);
        end

        head_next = head_reg;
        if (cmd.head_inc)
        begin
            if (head_reg == sdwq_pkg::addr_t'(sdwq_pkg::QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + sdwq_pkg::addr_t'(1);
            end
        end
    end

    // Held tick result
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_thread_next = pend_thread_reg;
        if (cmd.pend_load)
        begin
            pend_valid_next  = 1'b1;
            pend_thread_next = rd_entry.thread;
        end
        else if (cmd.out_op == sdwq_pkg::OUT_PEND_LAST)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Result register load and drain
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        woken_valid_next  = woken_valid_reg;
        woken_thread_next = woken_thread_reg;
        full_error_next   = full_error_reg;
        last_next         = last_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (cmd.out_op)
            sdwq_pkg::OUT_ERR:
            begin
                out_valid_next    = 1'b1;
                woken_valid_next  = 1'b0;
                woken_thread_next = '0;
                full_error_next   = 1'b1;
                last_next         = 1'b1;
            end
            sdwq_pkg::OUT_WAKE:
            begin
                out_valid_next    = 1'b1;
                woken_valid_next  = 1'b1;
                woken_thread_next = thread_reg;
                full_error_next   = 1'b0;
                last_next         = 1'b1;
            end
            sdwq_pkg::OUT_PEND_MID:
            begin
                out_valid_next    = 1'b1;
                woken_valid_next  = 1'b1;
                woken_thread_next = pend_thread_reg;
                full_error_next   = 1'b0;
                last_next         = 1'b0;
            end
            sdwq_pkg::OUT_PEND_LAST:
            begin
                out_valid_next    = 1'b1;
                woken_valid_next  = 1'b1;
                woken_thread_next = pend_thread_reg;
                full_error_next   = 1'b0;
                last_next         = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            head_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        thread_reg       <= thread_next;
        key_reg          <= key_next;
        idx_reg          <= idx_next;
        pend_thread_reg  <= pend_thread_next;
        woken_valid_reg  <= woken_valid_next;
        woken_thread_reg <= woken_thread_next;
        full_error_reg   <= full_error_next;
        last_reg         <= last_next;
    end

    // Status to the controller
    always_comb
    begin
        status.mode            = mode_reg;
        status.full            = (count_reg == sdwq_pkg::count_t'(sdwq_pkg::QUEUE_DEPTH));
        status.count_zero      = (count_reg == '0);
        status.idx_zero        = (idx_reg == '0);
        status.idx_lt_count    = (idx_reg < count_reg);
        status.idx_p1_lt_count = ((idx_ext + sdwq_pkg::logical_t'(1)) < {1'b0, count_reg});
        status.rd_le_key       = (rd_entry.deadline <= key_reg);
        status.rd_match        = (rd_entry.thread == thread_reg);
        status.slot_free       = slot_free;
        status.pend_valid      = pend_valid_reg;
        status.count           = count_reg;
    end

    assign out_valid    = out_valid_reg;
    assign woken_valid  = woken_valid_reg;
    assign woken_thread = woken_thread_reg;
    assign full_error   = full_error_reg;
    assign last         = last_reg;

endmodule

>>> src/sdwq_ctrl.sv
// Controller: sequences insert, tick and early-wake walks over the entry RAM.
module sdwq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sdwq_pkg::status_t    status,
    output sdwq_pkg::cmd_t       cmd
);

    sdwq_pkg::state_t state_reg, state_next;
    logic             tick_due;

    // Head entry is due when present and not after the request time
    assign tick_due = !status.count_zero && status.rd_le_key;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sdwq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sdwq_pkg::ST_DISPATCH;
                end
            end
            sdwq_pkg::ST_DISPATCH:
            begin
                case (sdwq_pkg::mode_t'(status.mode))
                    sdwq_pkg::MODE_SLEEP:
                    begin
                        state_next = status.full ? sdwq_pkg::ST_FULL_ERR
                                                 : sdwq_pkg::ST_INS_SCAN;
                    end
                    sdwq_pkg::MODE_TICK: state_next = sdwq_pkg::ST_TICK_SCAN;
                    sdwq_pkg::MODE_WAKE: state_next = sdwq_pkg::ST_WAKE_SCAN;
                    default:             state_next = sdwq_pkg::ST_IDLE;
                endcase
            end
            sdwq_pkg::ST_INS_SCAN:
            begin
                if (status.idx_zero || status.rd_le_key)
                begin
                    state_next = sdwq_pkg::ST_IDLE;
                end
            end
            sdwq_pkg::ST_FULL_ERR:
            begin
                if (status.slot_free)
                begin
                    state_next = sdwq_pkg::ST_IDLE;
                end
            end
            sdwq_pkg::ST_TICK_SCAN:
            begin
                if (!tick_due && (!status.pend_valid || status.slot_free))
                begin
                    state_next = sdwq_pkg::ST_IDLE;
                end
            end
            sdwq_pkg::ST_WAKE_SCAN:
            begin
                if (!status.idx_lt_count)
                begin
                    state_next = sdwq_pkg::ST_IDLE;
                end
                else if (status.rd_match && status.slot_free)
                begin
                    state_next = sdwq_pkg::ST_WAKE_SHIFT;
                end
            end
            sdwq_pkg::ST_WAKE_SHIFT:
            begin
                if (!status.idx_p1_lt_count)
                begin
                    state_next = sdwq_pkg::ST_IDLE;
                end
            end
            default: state_next = sdwq_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            sdwq_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            sdwq_pkg::ST_DISPATCH:
            begin
                case (sdwq_pkg::mode_t'(status.mode))
                    sdwq_pkg::MODE_SLEEP:
                    begin
                        if (!status.full)
                        begin
                            cmd.idx_op = sdwq_pkg::IDX_COUNT;
                            cmd.rd_op  = sdwq_pkg::RD_TAIL;
                        end
                    end
                    sdwq_pkg::MODE_TICK:
                    begin
                        cmd.rd_op = sdwq_pkg::RD_HEAD;
                    end
                    sdwq_pkg::MODE_WAKE:
                    begin
                        cmd.idx_op = sdwq_pkg::IDX_ZERO;
                        cmd.rd_op  = sdwq_pkg::RD_HEAD;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sdwq_pkg::ST_INS_SCAN:
            begin
                // Walk down from the tail, moving later deadlines up one place
                if (status.idx_zero || status.rd_le_key)
                begin
                    cmd.wr_op   = sdwq_pkg::WR_NEW;
                    cmd.cnt_inc = 1'b1;
                end
                else
                begin
                    cmd.wr_op  = sdwq_pkg::WR_MOVE;
                    cmd.rd_op  = sdwq_pkg::RD_IDX_M2;
                    cmd.idx_op = sdwq_pkg::IDX_DEC;
                end
            end
            sdwq_pkg::ST_FULL_ERR:
            begin
                if (status.slot_free)
                begin
                    cmd.out_op = sdwq_pkg::OUT_ERR;
                end
            end
            sdwq_pkg::ST_TICK_SCAN:
            begin
                // One result is held back until it is known whether it is the last
                if (tick_due)
                begin
                    if (!status.pend_valid || status.slot_free)
                    begin
                        if (status.pend_valid)
                        begin
                            cmd.out_op = sdwq_pkg::OUT_PEND_MID;
                        end
                        cmd.pend_load = 1'b1;
                        cmd.cnt_dec   = 1'b1;
                        cmd.head_inc  = 1'b1;
                        cmd.rd_op     = sdwq_pkg::RD_HEAD_NEXT;
                    end
                end
                else if (status.pend_valid && status.slot_free)
                begin
                    cmd.out_op = sdwq_pkg::OUT_PEND_LAST;
                end
            end
            sdwq_pkg::ST_WAKE_SCAN:
            begin
                if (status.idx_lt_count)
                begin
                    if (status.rd_match)
                    begin
                        if (status.slot_free)
                        begin
                            cmd.out_op = sdwq_pkg::OUT_WAKE;
                            cmd.rd_op  = sdwq_pkg::RD_IDX_P1;
                        end
                    end
                    else
                    begin
                        cmd.rd_op  = sdwq_pkg::RD_IDX_P1;
                        cmd.idx_op = sdwq_pkg::IDX_INC;
                    end
                end
            end
            sdwq_pkg::ST_WAKE_SHIFT:
            begin
                // Close the gap left by the woken entry
                if (status.idx_p1_lt_count)
                begin
                    cmd.wr_op  = sdwq_pkg::WR_MOVE;
                    cmd.rd_op  = sdwq_pkg::RD_IDX_P2;
                    cmd.idx_op = sdwq_pkg::IDX_INC;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdwq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> test/sorted_deadline_wake_queue_checker.sv
// Request/result monitor with wake queue predictor and field-by-field result compare.
`timescale 1ns / 1ps
module sorted_deadline_wake_queue_checker
    import sdwq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [TID_W-1:0]  thread_id,
    input  logic [DL_W-1:0]   sleep_clocks,
    input  logic [DL_W-1:0]   now_time,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              woken_valid,
    input  logic [TID_W-1:0]  woken_thread,
    input  logic              full_error,
    input  logic              last,
    output int                fail_count,
    output int                awaiting,
    output int                request_total,
    output int                wake_total,
    output int                reject_total
);

    // A tick never wakes more than this many sleepers at once
    localparam int MAX_WAKES = 16;

    typedef struct packed {
        logic             woken_valid;
        logic [TID_W-1:0] woken_thread;
        logic             full_error;
        logic             last;
    } wake_result_t;

    // Predicted queue contents, kept sorted by deadline
    logic [DL_W-1:0]  sleep_deadline [QUEUE_DEPTH];
    logic [TID_W-1:0] sleep_thread [QUEUE_DEPTH];
    int               sleeper_count = 0;

    wake_result_t     expected_wakes [$];

    int miss_total    = 0;
    int pending_total = 0;
    int seen_requests = 0;
    int seen_wakes    = 0;
    int seen_rejects  = 0;

    assign fail_count    = miss_total;
    assign awaiting      = pending_total;
    assign request_total = seen_requests;
    assign wake_total    = seen_wakes;
    assign reject_total  = seen_rejects;

    function automatic wake_result_t make_result(input logic v, input logic [TID_W-1:0] t,
                                                 input logic e, input logic l);
        wake_result_t r;
        r.woken_valid  = v;
        r.woken_thread = t;
        r.full_error   = e;
        r.last         = l;
        return r;
    endfunction

    // Close the gap left by a removed sleeper
    task automatic drop_sleeper(input int pos);
        int i;
        for (i = pos; i + 1 < sleeper_count; i++)
        begin
            sleep_deadline[i] = sleep_deadline[i + 1];
            sleep_thread[i]   = sleep_thread[i + 1];
        end
        sleeper_count--;
    endtask

    // Apply one accepted request to the predicted queue, queue its results
    task automatic predict_queue_step(input logic [MODE_W-1:0] op, input logic [TID_W-1:0] tid,
                                      input logic [DL_W-1:0] dur, input logic [DL_W-1:0] t_now);
        logic [DL_W-1:0] wake_at;
        int              pos;
        int              i;
        int              n;
        wake_result_t    r;
        case (op)
            MODE_SLEEP:
            begin
                wake_at = t_now + dur;
                if (sleeper_count >= QUEUE_DEPTH)
                begin
                    expected_wakes.push_back(make_result(1'b0, '0, 1'b1, 1'b1));
                end
                else
                begin
                    // equal deadlines keep arrival order
                    pos = 0;
                    while (pos < sleeper_count && sleep_deadline[pos] <= wake_at)
                    begin
                        pos++;
                    end
                    for (i = sleeper_count; i > pos; i--)
                    begin
                        sleep_deadline[i] = sleep_deadline[i - 1];
                        sleep_thread[i]   = sleep_thread[i - 1];
                    end
                    sleep_deadline[pos] = wake_at;
                    sleep_thread[pos]   = tid;
                    sleeper_count++;
                end
            end
            MODE_TICK:
            begin
                n = 0;
                while (n < MAX_WAKES && sleeper_count > 0 && sleep_deadline[0] <= t_now)
                begin
                    expected_wakes.push_back(make_result(1'b1, sleep_thread[0], 1'b0, 1'b0));
                    drop_sleeper(0);
                    n++;
                end
                if (n > 0)
                begin
                    r = expected_wakes.pop_back();
                    r.last = 1'b1;
                    expected_wakes.push_back(r);
                end
            end
            MODE_WAKE:
            begin
                pos = 0;
                while (pos < sleeper_count && sleep_thread[pos] != tid)
                begin
                    pos++;
                end
                if (pos < sleeper_count)
                begin
                    expected_wakes.push_back(make_result(1'b1, tid, 1'b0, 1'b1));
                    drop_sleeper(pos);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [TID_W-1:0] want,
                               input logic [TID_W-1:0] got);
        if (got !== want)
        begin
            miss_total++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Results are taken before requests: a result at this edge belongs to an older request
    always @(posedge clk)
    begin
        wake_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (woken_valid === 1'b1)
                begin
                    seen_wakes++;
                end
                if (full_error === 1'b1)
                begin
                    seen_rejects++;
                end
                if (expected_wakes.size() == 0)
                begin
                    miss_total++;
                    $display("%0t: unexpected result: expected none, actual valid=%0d thread=%0d err=%0d last=%0d",
                             $time, woken_valid, woken_thread, full_error, last);
                end
                else
                begin
                    want = expected_wakes.pop_front();
                    check_field("woken_valid", TID_W'(want.woken_valid), TID_W'(woken_valid));
                    check_field("woken_thread", want.woken_thread, woken_thread);
                    check_field("full_error", TID_W'(want.full_error), TID_W'(full_error));
                    check_field("last", TID_W'(want.last), TID_W'(last));
                end
            end
            if (in_valid && !in_stall)
            begin
                seen_requests++;
                predict_queue_step(mode, thread_id, sleep_clocks, now_time);
            end
            pending_total = expected_wakes.size();
        end
    end

endmodule

>>> test/sorted_deadline_wake_queue_core_test.sv
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module sorted_deadline_wake_queue_core_test;
    import sdwq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam logic [DL_W-1:0]   TIME_MAX     = '1;
    localparam int                LONG_HOLD    = 300;
    localparam int                QUIET_LIMIT  = 5000;
    localparam int                DRAIN_CYCLES = 40;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [MODE_W-1:0] mode         = MODE_SLEEP;
    logic [TID_W-1:0]  thread_id    = '0;
    logic [DL_W-1:0]   sleep_clocks = '0;
    logic [DL_W-1:0]   now_time     = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              woken_valid;
    logic [TID_W-1:0]  woken_thread;
    logic              full_error;
    logic              last;

    int fail_count;
    int awaiting;
    int request_total;
    int wake_total;
    int reject_total;

    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    logic            hold_start     = 1'b0;
    int              hold_left      = 0;
    int              quiet_cycles   = 0;
    logic [DL_W-1:0] clock_now      = '0;

    sorted_deadline_wake_queue_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .thread_id    (thread_id),
        .sleep_clocks (sleep_clocks),
        .now_time     (now_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .woken_valid  (woken_valid),
        .woken_thread (woken_thread),
        .full_error   (full_error),
        .last         (last)
    );

    sorted_deadline_wake_queue_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .thread_id     (thread_id),
        .sleep_clocks  (sleep_clocks),
        .now_time      (now_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .woken_valid   (woken_valid),
        .woken_thread  (woken_thread),
        .full_error    (full_error),
        .last          (last),
        .fail_count    (fail_count),
        .awaiting      (awaiting),
        .request_total (request_total),
        .wake_total    (wake_total),
        .reject_total  (reject_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off once asked for
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        out_stall <= (hold_start || hold_left > 1) ? 1'b1
                                                    : ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("[sorted_deadline_wake_queue_core] ERROR");
            $finish;
        end
    end

    // Offer one request, after an optional random gap, and hold it until taken
    task automatic offer_request(input logic [MODE_W-1:0] op, input logic [TID_W-1:0] tid,
                                 input logic [DL_W-1:0] dur, input logic [DL_W-1:0] t_now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= op;
        thread_id    <= tid;
        sleep_clocks <= dur;
        now_time     <= t_now;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Random traffic on a rising time base; mostly small pool of threads so wakes hit
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input logic [DL_W-1:0] phase_base);
        int              taken;
        int              pick;
        logic [TID_W-1:0] tid;
        logic [DL_W-1:0] dur;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        clock_now      = phase_base;
        taken          = 0;
        while (taken < count)
        begin
            pick = $urandom_range(99);
            tid  = ($urandom_range(7) == 0) ? TID_W'($urandom) : TID_W'($urandom_range(15));
            if (pick < 45)
            begin
                case ($urandom_range(9))
                    0:       dur = '0;
                    1:       dur = {$urandom, $urandom};
                    default: dur = DL_W'($urandom_range(300));
                endcase
                offer_request(MODE_SLEEP, tid, dur, clock_now);
                taken++;
            end
            else if (pick < 75)
            begin
                clock_now = clock_now + DL_W'($urandom_range(150));
                if ($urandom_range(19) == 0)
                begin
                    offer_request(MODE_TICK, tid, {$urandom, $urandom}, {$urandom, $urandom});
                end
                else
                begin
                    offer_request(MODE_TICK, tid, {$urandom, $urandom}, clock_now);
                end
                taken++;
            end
            else if (pick < 95)
            begin
                offer_request(MODE_WAKE, tid, {$urandom, $urandom}, clock_now);
                taken++;
            end
            else
            begin
                // ignored code, random fields
                offer_request(MODE_UNUSED, TID_W'($urandom), {$urandom, $urandom},
                              {$urandom, $urandom});
            end
        end
        // flush whatever is due so the next phase starts from a short queue
        offer_request(MODE_TICK, '0, '0, TIME_MAX);
    endtask

    initial
    begin
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, ignored code, wrap of the deadline sum, ties, full, big tick
        offer_request(MODE_TICK, '0, '0, '0);
        offer_request(MODE_WAKE, 8'd5, '0, '0);
        offer_request(MODE_UNUSED, 8'hA5, TIME_MAX, TIME_MAX);
        offer_request(MODE_SLEEP, 8'd255, TIME_MAX, TIME_MAX);
        offer_request(MODE_SLEEP, 8'd0, 64'd10, TIME_MAX - 64'd4);
        offer_request(MODE_SLEEP, 8'd1, 64'd5, '0);
        offer_request(MODE_SLEEP, 8'd1, '0, '0);
        offer_request(MODE_WAKE, 8'd1, '0, '0);
        offer_request(MODE_WAKE, 8'd200, '0, '0);
        for (k = 0; k < 13; k++)
        begin
            offer_request(MODE_SLEEP, TID_W'(16 + k), DL_W'(k), 64'd100);
        end
        offer_request(MODE_SLEEP, 8'd77, 64'd1, 64'd1);
        offer_request(MODE_TICK, '0, '0, TIME_MAX);
        offer_request(MODE_TICK, '0, '0, TIME_MAX);

        // Random phases under different idle mixes; one starts just short of the wrap
        run_phase(0, 0, 40, DL_W'($urandom));
        run_phase(45, 0, 40, TIME_MAX - 64'd3000);
        run_phase(0, 45, 40, {$urandom, $urandom});
        run_phase(37, 37, 40, DL_W'($urandom_range(1000)));

        // Back-pressure: hold results off while requests keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (k = 0; k < 16; k++)
        begin
            offer_request(MODE_SLEEP, TID_W'($urandom), DL_W'($urandom_range(50)), clock_now);
        end
        offer_request(MODE_TICK, '0, '0, TIME_MAX);
        for (k = 0; k < 6; k++)
        begin
            offer_request(MODE_SLEEP, TID_W'(k), '0, clock_now);
            offer_request(MODE_TICK, '0, '0, clock_now);
        end
        in_valid <= 1'b0;

        // Drain: everything predicted must arrive, then nothing more
        recv_stall_pct = 20;
        do
        begin
            @(negedge clk);
        end
        while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Covered %0d requests: %0d threads woken, %0d full-queue rejects.",
                 request_total, wake_total, reject_total);
        $display("Phases: directed corners, four idle/stall mixes, one long result hold-off.");
        if (awaiting != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, awaiting);
        end
        if (fail_count == 0 && awaiting == 0)
        begin
            $display("[sorted_deadline_wake_queue_core] OK");
        end
        else
        begin
            $display("[sorted_deadline_wake_queue_core] ERROR");
        end
        $finish;
    end

endmodule

>>> sorted_deadline_wake_queue_core.f
src/sdwq_pkg.sv
src/sdwq_ram.sv
src/sdwq_dpath.sv
src/sdwq_ctrl.sv
src/sorted_deadline_wake_queue_core.sv
test/sorted_deadline_wake_queue_checker.sv
test/sorted_deadline_wake_queue_core_test.sv
